// ===== src/sbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring counter package
// Shared widths, register codes and payload types of the substring counter.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 6;   // key_length register width
  localparam int LEN_EXT_W      = 7;   // holds any key length up to 64
  localparam int COUNT_W        = 32;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int BYTES_PER_REG  = CFG_DATA_W / BYTE_W;
  localparam int KEY_REG_BYTES  = 4 * BYTES_PER_REG;  // bytes reachable by writes

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LENGTH = 3'd0,
    REG_KEY_0_7    = 3'd1,
    REG_KEY_8_15   = 3'd2,
    REG_KEY_16_23  = 3'd3,
    REG_KEY_24_31  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } sbc_in_t;

  typedef struct packed {
    logic               match_ends_here;
    logic [COUNT_W-1:0] occurrence_count;
    logic               last_of_text;
  } sbc_out_t;

  // Per-transfer control broadcast to the history cells
  typedef struct packed {
    logic shift;
    logic clear;
  } sbc_ctl_t;

endpackage
`default_nettype wire

// ===== src/sbc_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring counter stream interface
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface sbc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/sbc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring counter history cell
// Holds one past text byte and its fill flag, passes both on to the next
// cell on each shift, and compares its byte against the key byte it is given.
// ----------------------------------------------------------------------------
module sbc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbc_pkg::sbc_ctl_t        ctl_i,
  input  logic [sbc_pkg::BYTE_W-1:0] byte_i,
  input  logic                     fill_i,
  input  logic [sbc_pkg::BYTE_W-1:0] key_byte_i,
  input  logic                     care_i,
  output logic [sbc_pkg::BYTE_W-1:0] byte_o,
  output logic                     fill_o,
  output logic                     hit_o
);
  import sbc_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic              fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 1'b0;
    end else if (ctl_i.clear) begin
      fill_q <= 1'b0;
    end else if (ctl_i.shift) begin
      fill_q <= fill_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign fill_o = fill_q;
  // positions outside the active key always agree
  assign hit_o  = !care_i || (fill_q && (byte_q == key_byte_i));

endmodule
`default_nettype wire

// ===== src/sbc_key_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring counter key registers
// Key length and key bytes written through the config port; presents the key
// right-aligned and reversed, so byte j is the key byte that must match the
// text byte j positions back.
// ----------------------------------------------------------------------------
module sbc_key_regs #(
  parameter int KEY_MAX = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [sbc_pkg::LEN_EXT_W-1:0]    len_o,
  output logic [KEY_MAX*sbc_pkg::BYTE_W-1:0] rkey_o
);
  import sbc_pkg::*;

  localparam logic [LEN_EXT_W-1:0] KeyMaxLen = LEN_EXT_W'(KEY_MAX);

  logic [LEN_W-1:0]                len_q;
  logic [BYTE_W-1:0]               key_q [KEY_MAX];
  logic [KEY_MAX*BYTE_W-1:0]       rev_key;
  logic [LEN_EXT_W-1:0]            len_ext;
  logic [LEN_EXT_W-1:0]            len_eff;
  logic [LEN_EXT_W-1:0]            shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_we_i && (cfg_idx_i == REG_KEY_LENGTH)) begin
      len_q <= cfg_data_i[LEN_W-1:0];
    end
  end

  for (genvar p = 0; p < KEY_MAX; p++) begin : g_key
    if (p < KEY_REG_BYTES) begin : g_wr
      localparam logic [CFG_IDX_W-1:0] RegSel =
        CFG_IDX_W'(int'(REG_KEY_0_7) + p / BYTES_PER_REG);
      localparam int Lsb = (p % BYTES_PER_REG) * BYTE_W;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          key_q[p] <= '0;
        end else if (cfg_we_i && (cfg_idx_i == RegSel)) begin
          key_q[p] <= cfg_data_i[Lsb +: BYTE_W];
        end
      end
    end else begin : g_zero
      assign key_q[p] = '0;
    end
    assign rev_key[p*BYTE_W +: BYTE_W] = key_q[KEY_MAX-1-p];
  end

  assign len_ext = {1'b0, len_q};
  assign len_eff = (len_ext > KeyMaxLen) ? KeyMaxLen : len_ext;
  // byte j of the result is key[len-1-j]
  assign shamt   = KeyMaxLen - len_eff;
  assign rkey_o  = rev_key >> {shamt, 3'b000};
  assign len_o   = len_eff;

endmodule
`default_nettype wire

// ===== src/substring_occurrence_counter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Substring occurrence counter
// Streams text bytes through a row of history cells and flags every byte at
// which the configured key ends, overlaps included, with a running count.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  text_i    in   text_byte[7:0], end_of_text                      valid/ready
//  result_o  out  match_ends_here, occurrence_count[31:0], last    valid/ready
//  cfg_*     in   cfg_idx_i[2:0], cfg_data_i[63:0]                  cfg_we_i
//
//  One byte per cycle; each result is registered and shows in the next cycle.
//  All key positions compare in the same cycle against the cell row, so the
//  rate is set only by the output register being taken downstream.
//  A stalled result holds; a new byte is still taken when the result leaves
//  in the same cycle. Reset clears history, count and key (length 1).
//  The byte marked end_of_text clears history and count after its result.
// ----------------------------------------------------------------------------
module substring_occurrence_counter_top #(
  parameter int KEY_MAX = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sbc_stream_if.sink                     text_i,
  sbc_stream_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sbc_pkg::*;

  localparam int NCell = (KEY_MAX > 1) ? KEY_MAX - 1 : 1;

  logic [LEN_EXT_W-1:0]          len_w;
  logic [KEY_MAX*BYTE_W-1:0]     rkey;
  logic [(NCell+1)*BYTE_W-1:0]   rkey_pad;
  logic [BYTE_W-1:0]             byte_w [NCell];
  logic [NCell-1:0]              fill_w;
  logic [NCell-1:0]              hit_w;
  sbc_ctl_t                      ctl;
  sbc_in_t                       din;
  logic                          in_acc;
  logic                          cur_hit;
  logic                          hit;
  logic [COUNT_W-1:0]            cnt_q, cnt_d, cnt_new;
  logic                          out_valid_q, out_valid_d;
  sbc_out_t                      out_q, out_d;

  sbc_key_regs #(
    .KEY_MAX (KEY_MAX)
  ) u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .len_o      (len_w),
    .rkey_o     (rkey)
  );

  assign rkey_pad = ((NCell+1)*BYTE_W)'(rkey);

  assign din          = text_i.data;
  assign text_i.ready = !out_valid_q || result_o.ready;
  assign in_acc       = text_i.valid && text_i.ready;

  assign ctl.shift = in_acc && !din.end_of_text;
  assign ctl.clear = in_acc && din.end_of_text;

  // cell k holds the text byte k+1 positions back
  for (genvar k = 0; k < NCell; k++) begin : g_cell
    localparam logic [LEN_EXT_W-1:0] Age = LEN_EXT_W'(k + 1);
    logic [BYTE_W-1:0] byte_in;
    logic              fill_in;

    if (k == 0) begin : g_head
      assign byte_in = din.text_byte;
      assign fill_in = 1'b1;
    end else begin : g_body
      assign byte_in = byte_w[k-1];
      assign fill_in = fill_w[k-1];
    end

    sbc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .byte_i     (byte_in),
      .fill_i     (fill_in),
      .key_byte_i (rkey_pad[(k+1)*BYTE_W +: BYTE_W]),
      .care_i     (Age < len_w),
      .byte_o     (byte_w[k]),
      .fill_o     (fill_w[k]),
      .hit_o      (hit_w[k])
    );
  end

  assign cur_hit = (din.text_byte == rkey_pad[BYTE_W-1:0]);
  assign hit     = (len_w != '0) && cur_hit && (&hit_w);
  assign cnt_new = cnt_q + COUNT_W'(hit && (cnt_q != '1));

  always_comb begin
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    if (in_acc) begin
      cnt_d                  = din.end_of_text ? '0 : cnt_new;
      out_valid_d            = 1'b1;
      out_d.match_ends_here  = hit;
      out_d.occurrence_count = cnt_new;
      out_d.last_of_text     = din.end_of_text;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // a match always leaves a nonzero count behind it
  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.match_ends_here |-> out_q.occurrence_count != '0)
    else $error("match reported with zero count");

  // end of text empties history and count
  a_text_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && din.end_of_text |=> (cnt_q == '0) && (fill_w == '0))
    else $error("history or count not cleared after end of text");

  // cells fill from the head: an older cell never filled ahead of a newer one
  a_fill_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fill_w >> 1) & ~fill_w) == '0)
    else $error("history fill flags out of order");

  // within a text the count never goes down
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !din.end_of_text |=> cnt_q >= $past(cnt_q))
    else $error("running count decreased within a text");

endmodule
`default_nettype wire

// ===== tb/tb_substring_occurrence_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substring occurrence counter testbench
// Streams texts built around the programmed key, with runs of the key,
// overlapping copies, broken prefixes and random bytes. A local predictor
// gives the flag, count and end mark of every byte, and each result is
// compared with the oldest prediction. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_substring_occurrence_counter_top;
  import sbc_pkg::*;

  localparam int KEY_MAX         = 32;
  localparam int CLK_PERIOD      = 2;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int LONG_HOLD       = 60;
  localparam int MAX_PRINTED     = 200;

  typedef enum int {KEY_RANDOM, KEY_REPEAT, KEY_PERIOD2, KEY_EXTREMES} key_shape_e;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbc_stream_if #(.T(sbc_in_t))  text_if ();
  sbc_stream_if #(.T(sbc_out_t)) result_if ();

  substring_occurrence_counter_top #(
    .KEY_MAX (KEY_MAX)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .text_i     (text_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state and configuration
  logic [BYTE_W-1:0]  key_mem [KEY_MAX];
  logic [LEN_W-1:0]   key_len_reg;
  logic [BYTE_W-1:0]  history [KEY_MAX-1];
  int unsigned        hist_fill;
  logic [COUNT_W-1:0] occ_count;

  logic [BYTE_W-1:0] key_plan [KEY_REG_BYTES];
  logic [LEN_W-1:0]  phase_len [PHASES] =
    '{6'd32, 6'd1, 6'd63, 6'd5, 6'd17, 6'd33, 6'd2, 6'd0, 6'd9, 6'd4};

  sbc_in_t  pending_text [$];
  sbc_out_t expected_results [$];

  bit          text_moved;
  bit          idling_on;
  int unsigned send_idle;
  int unsigned sink_idle;
  int unsigned hold_left;
  int unsigned stall_request;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;

  function automatic sbc_out_t count_occurrence(sbc_in_t item);
    int unsigned len;
    int          j;
    bit          hit;
    sbc_out_t    res;
    len = key_len_reg;
    if (len > KEY_MAX) len = KEY_MAX;
    hit = 1'b0;
    if (len != 0 && hist_fill + 1 >= len) begin
      hit = (key_mem[len-1] == item.text_byte);
      for (j = 1; j < len; j++) begin
        if (key_mem[len-1-j] != history[j-1]) hit = 1'b0;
      end
    end
    if (hit && occ_count != '1) occ_count++;
    res.match_ends_here  = hit;
    res.occurrence_count = occ_count;
    res.last_of_text     = item.end_of_text;
    if (item.end_of_text) begin
      foreach (history[k]) history[k] = '0;
      hist_fill = 0;
      occ_count = '0;
    end else begin
      for (j = KEY_MAX - 2; j >= 1; j--) history[j] = history[j-1];
      history[0] = item.text_byte;
      if (hist_fill < KEY_MAX - 1) hist_fill++;
    end
    return res;
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    int b;
    int pos;
    case (idx)
      REG_KEY_LENGTH: key_len_reg = value[LEN_W-1:0];
      REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31: begin
        for (b = 0; b < BYTES_PER_REG; b++) begin
          pos = (int'(idx) - int'(REG_KEY_0_7)) * BYTES_PER_REG + b;
          if (pos < KEY_MAX) key_mem[pos] = value[b*BYTE_W +: BYTE_W];
        end
      end
      default: ;
    endcase
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    store_reg(idx, value);
  endtask

  task automatic plan_key(key_shape_e shape);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] c;
    int i;
    a = BYTE_W'($urandom_range(0, 255));
    c = BYTE_W'($urandom_range(0, 255));
    for (i = 0; i < KEY_REG_BYTES; i++) begin
      case (shape)
        KEY_REPEAT:   key_plan[i] = a;
        KEY_PERIOD2:  key_plan[i] = (i % 2) ? c : a;
        KEY_EXTREMES: key_plan[i] = (i % 2) ? 8'hFF : 8'h00;
        default:      key_plan[i] = BYTE_W'($urandom_range(0, 255));
      endcase
    end
  endtask

  task automatic program_key(logic [LEN_W-1:0] len_field);
    logic [CFG_DATA_W-1:0] word;
    int r;
    int b;
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = len_field;
    write_reg(REG_KEY_LENGTH, word);
    for (r = 0; r < 4; r++) begin
      for (b = 0; b < BYTES_PER_REG; b++)
        word[b*BYTE_W +: BYTE_W] = key_plan[r*BYTES_PER_REG + b];
      write_reg(CFG_IDX_W'(int'(REG_KEY_0_7) + r), word);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Texts mostly made of whole and partial key copies, so matches and
  // overlaps are common; the rest is noise.
  task automatic queue_texts(int unsigned n_bytes);
    int unsigned made;
    int unsigned text_len;
    int unsigned eff;
    int unsigned mode;
    int unsigned cut;
    int unsigned j;
    logic [BYTE_W-1:0] text_buf [$];
    sbc_in_t item;
    made = 0;
    eff = (key_len_reg > KEY_MAX) ? KEY_MAX : key_len_reg;
    @(posedge clk);
    while (made < n_bytes) begin
      text_buf = {};
      text_len = $urandom_range(1, 2 * eff + 12);
      while (text_buf.size() < text_len) begin
        mode = $urandom_range(0, 9);
        if (mode < 5 && eff > 0) begin
          for (j = 0; j < eff; j++) text_buf.push_back(key_mem[j]);
        end else if (mode < 7 && eff > 1) begin
          cut = $urandom_range(1, eff - 1);
          for (j = 0; j < cut; j++) text_buf.push_back(key_mem[j]);
          text_buf.push_back(BYTE_W'($urandom_range(0, 255)));
        end else if (mode < 9 && eff > 0) begin
          text_buf.push_back(key_mem[$urandom_range(0, eff - 1)]);
        end else begin
          text_buf.push_back(BYTE_W'($urandom_range(0, 255)));
        end
      end
      // last text of the phase is cut to the byte budget
      while (text_buf.size() > n_bytes - made) void'(text_buf.pop_back());
      foreach (text_buf[k]) begin
        item.text_byte   = text_buf[k];
        item.end_of_text = (k == text_buf.size() - 1);
        pending_text.push_back(item);
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_text.size() != 0 || expected_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Sender: holds an offered byte until its transfer, idles in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      text_if.valid <= 1'b0;
    end else if (text_if.valid && !text_moved) begin
      // offer stands until taken
    end else if (send_idle != 0) begin
      send_idle--;
      text_if.valid <= 1'b0;
    end else if (pending_text.size() != 0) begin
      if (idling_on && $urandom_range(0, 7) == 0) begin
        send_idle = $urandom_range(0, 11);
        text_if.valid <= 1'b0;
      end else begin
        text_if.valid <= 1'b1;
        text_if.data  <= pending_text[0];
      end
    end else begin
      text_if.valid <= 1'b0;
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (sink_idle != 0) begin
        sink_idle--;
        result_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        sink_idle = $urandom_range(0, 11);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every byte transfer, check on every result transfer
  always @(posedge clk) begin
    sbc_out_t want;
    text_moved = rst_n && text_if.valid && text_if.ready;
    if (text_moved) begin
      expected_results.push_back(count_occurrence(text_if.data));
      void'(pending_text.pop_front());
    end
    if (rst_n && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", result_if.data, 0);
      end else begin
        want = expected_results.pop_front();
        if (result_if.data.match_ends_here !== want.match_ends_here)
          report_mismatch("match_ends_here", result_if.data.match_ends_here,
                          want.match_ends_here);
        if (result_if.data.occurrence_count !== want.occurrence_count)
          report_mismatch("occurrence_count", result_if.data.occurrence_count,
                          want.occurrence_count);
        if (result_if.data.last_of_text !== want.last_of_text)
          report_mismatch("last_of_text", result_if.data.last_of_text,
                          want.last_of_text);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int i;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    text_if.valid   = 1'b0;
    text_if.data    = '0;
    result_if.ready = 1'b0;
    text_moved      = 1'b0;
    idling_on       = 1'b1;
    send_idle       = 0;
    sink_idle       = 0;
    hold_left       = 0;
    stall_request   = 0;
    quiet_cycles    = 0;
    mismatch_count  = 0;
    foreach (key_mem[k]) key_mem[k] = '0;
    foreach (history[k]) history[k] = '0;
    key_len_reg = 6'd1;
    hist_fill   = 0;
    occ_count   = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset key: length 1, byte 0x00; extremes of the byte field
    @(posedge clk);
    pending_text.push_back({8'h00, 1'b0});
    pending_text.push_back({8'hFF, 1'b0});
    pending_text.push_back({8'h00, 1'b1});
    wait_drained();

    // Two-byte key: a text shorter than the key, then overlapping copies.
    // Writes to indexes past the last register must leave the key alone.
    foreach (key_plan[k]) key_plan[k] = BYTE_W'($urandom_range(0, 255));
    key_plan[0] = 8'hAB;
    key_plan[1] = 8'hAB;
    program_key(6'd2);
    for (i = int'(REG_KEY_24_31) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    pending_text.push_back({8'hAB, 1'b1});
    pending_text.push_back({8'hAB, 1'b0});
    pending_text.push_back({8'hAB, 1'b0});
    pending_text.push_back({8'hAB, 1'b1});
    wait_drained();

    // Zero-length key never matches
    program_key(6'd0);
    @(posedge clk);
    pending_text.push_back({8'hAB, 1'b0});
    pending_text.push_back({8'hAB, 1'b1});
    wait_drained();

    // Single-byte key at the top of the byte range
    key_plan[0] = 8'hFF;
    program_key(6'd1);
    @(posedge clk);
    pending_text.push_back({8'hFF, 1'b1});
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      idling_on = (p < PHASES - 2);
      plan_key(key_shape_e'(p % 4));
      program_key(phase_len[p]);
      queue_texts(ITEMS_PER_PHASE);
      // long receiver hold-off so the block backs up into the sender
      if (p == 0) stall_request = LONG_HOLD;
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
